// ----- src/khnd_pkg.sv -----
// ----------------------------------------------------------------------------
// khnd_pkg: shared types and constants for the k-ary heap node distance core
// Node and branching widths, divider geometry and the register reset value.
// ----------------------------------------------------------------------------
package khnd_pkg;

    localparam int NODE_W       = 50;
    localparam int BRANCH_W     = 10;
    localparam int RADIX_BITS   = 8;
    localparam int DIV_STEPS    = (NODE_W + 1 + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIV_W        = DIV_STEPS * RADIX_BITS;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    typedef logic [NODE_W-1:0]     node_t;
    typedef logic [BRANCH_W-1:0]   branch_t;
    typedef logic [DIV_W-1:0]      dividend_t;
    typedef logic [RADIX_BITS-1:0] digit_t;
    typedef logic [CNT_W-1:0]      step_cnt_t;

    localparam branch_t BRANCH_RESET = BRANCH_W'(2);

endpackage

// ----- src/kary_heap_node_distance_core.sv -----
// ----------------------------------------------------------------------------
// kary_heap_node_distance_core: edge count between two nodes of a k-ary heap
// Heap-numbered tree distance with a shared iterative parent-step divider.
// ----------------------------------------------------------------------------
// One transaction at a time. Node zero counts as the root; branching zero or
// one makes the tree a chain and the result is the difference of the two node
// numbers (node zero taken as one), passed through S_PICK and S_DONE into the
// output register. Otherwise the larger node number steps to its parent until
// the two meet; each parent step is a compare in S_PICK, then a radix-256
// restoring divider in S_DIV for (u + k - 2) / k over DIV_STEPS (7) digits.
// The result sits in an output register; a new transaction is accepted while
// it waits. Write branching only while the core is idle.
module kary_heap_node_distance_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [khnd_pkg::BRANCH_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [khnd_pkg::NODE_W-1:0] node_a,
    input  logic [khnd_pkg::NODE_W-1:0] node_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [khnd_pkg::NODE_W-1:0] distance
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                state_reg, state_next;
    khnd_pkg::branch_t         branching_reg, branching_next;
    logic                      out_valid_reg, out_valid_next;
    khnd_pkg::step_cnt_t       cnt_reg, cnt_next;
    logic                      climb_a_reg, climb_a_next;

    khnd_pkg::node_t           a_reg, a_next;
    khnd_pkg::node_t           b_reg, b_next;
    khnd_pkg::node_t           dist_reg, dist_next;
    khnd_pkg::node_t           distance_reg, distance_next;
    khnd_pkg::dividend_t       num_reg, num_next;
    khnd_pkg::dividend_t       quo_reg, quo_next;
    khnd_pkg::branch_t         rem_reg, rem_next;

    logic                      in_fire;
    logic                      chain;
    logic                      a_gt_b;
    khnd_pkg::node_t           larger;
    khnd_pkg::node_t           diff;
    khnd_pkg::digit_t          digit;
    khnd_pkg::branch_t         rem_step;
    logic [khnd_pkg::BRANCH_W:0] trial;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    assign chain  = (branching_reg <= khnd_pkg::BRANCH_W'(1));
    assign a_gt_b = (a_reg > b_reg);
    assign larger = a_gt_b ? a_reg : b_reg;
    assign diff   = a_gt_b ? (a_reg - b_reg) : (b_reg - a_reg);

    // Eight restoring steps of the shared divider.
    always_comb
    begin
        rem_step = rem_reg;
        digit    = '0;
        trial    = '0;
        for (int i = 0; i < khnd_pkg::RADIX_BITS; i++)
        begin
            trial = {rem_step, num_reg[khnd_pkg::DIV_W-1-i]};
            if (trial >= {1'b0, branching_reg})
            begin
                trial = trial - {1'b0, branching_reg};
                digit[khnd_pkg::RADIX_BITS-1-i] = 1'b1;
            end
            rem_step = trial[khnd_pkg::BRANCH_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        branching_next = branching_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        climb_a_next   = climb_a_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        dist_next      = dist_reg;
        distance_next  = distance_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;

        if (cfg_valid && cfg_ready)
        begin
            branching_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    a_next     = (node_a == '0) ? khnd_pkg::NODE_W'(1) : node_a;
                    b_next     = (node_b == '0) ? khnd_pkg::NODE_W'(1) : node_b;
                    dist_next  = '0;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (chain)
                begin
                    dist_next  = diff;
                    state_next = S_DONE;
                end
                else if (a_reg == b_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    climb_a_next = a_gt_b;
                    num_next     = khnd_pkg::DIV_W'(larger)
                                 + khnd_pkg::DIV_W'(branching_reg)
                                 - khnd_pkg::DIV_W'(2);
                    quo_next     = '0;
                    rem_next     = '0;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                num_next = {num_reg[khnd_pkg::DIV_W-khnd_pkg::RADIX_BITS-1:0],
                            khnd_pkg::RADIX_BITS'(0)};
                quo_next = {quo_reg[khnd_pkg::DIV_W-khnd_pkg::RADIX_BITS-1:0], digit};
                rem_next = rem_step;
                cnt_next = cnt_reg + khnd_pkg::CNT_W'(1);
                if (cnt_reg == khnd_pkg::CNT_W'(khnd_pkg::DIV_STEPS - 1))
                begin
                    if (climb_a_reg)
                    begin
                        a_next = quo_next[khnd_pkg::NODE_W-1:0];
                    end
                    else
                    begin
                        b_next = quo_next[khnd_pkg::NODE_W-1:0];
                    end
                    dist_next  = dist_reg + khnd_pkg::NODE_W'(1);
                    state_next = S_PICK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    distance_next  = dist_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            branching_reg <= khnd_pkg::BRANCH_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            climb_a_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            branching_reg <= branching_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            climb_a_reg   <= climb_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        dist_reg     <= dist_next;
        distance_reg <= distance_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
    end

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_PICK)
        else $error("accepted transaction did not start work");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < branching_reg)
        else $error("divider remainder not below branching");

    a_nodes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK || state_reg == S_DIV) |-> (a_reg != '0 && b_reg != '0))
        else $error("node register reached zero");

    a_div_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == khnd_pkg::CNT_W'(khnd_pkg::DIV_STEPS - 1))
        |=> state_reg == S_PICK)
        else $error("divider did not finish on its last step");

endmodule

// ----- dv/tb_kary_heap_node_distance_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kary_heap_node_distance_core: self-checking bench for the k-ary heap
// node distance core
// A directed table covers the extremes of both node numbers and of branching,
// node zero and the chain cases. Random phases follow, each loading a branching
// setting, mostly with pairs near each other in the tree. Table values or an
// internal distance model predict each transaction, and results are checked in
// order. Both sides stall in random bursts, with one long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_kary_heap_node_distance_core;

    localparam int      PHASES          = 10;
    localparam int      ITEMS_PER_PHASE = 103;
    localparam int      HOLD_CYCLES     = 3000;
    localparam int      PROBES          = 22;
    localparam longint  TIMEOUT_NS      = 40_000_000;
    localparam khnd_pkg::node_t NODE_MAX = '1;
    localparam khnd_pkg::node_t NODE_TOP =
        khnd_pkg::node_t'(1) << (khnd_pkg::NODE_W - 1);

    typedef struct {
        bit                set_k;
        khnd_pkg::branch_t k;
        khnd_pkg::node_t   a;
        khnd_pkg::node_t   b;
        bit                known;
        khnd_pkg::node_t   gold;
    } probe_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    khnd_pkg::branch_t cfg_data;
    logic              in_valid;
    logic              in_ready;
    khnd_pkg::node_t   node_a;
    khnd_pkg::node_t   node_b;
    logic              out_valid;
    logic              out_ready;
    khnd_pkg::node_t   distance;

    logic              typed_known;
    khnd_pkg::node_t   typed_dist;
    khnd_pkg::branch_t branch_model = khnd_pkg::BRANCH_RESET;
    khnd_pkg::node_t   distance_q[$];
    int                fail_count   = 0;
    bit                calm         = 1'b0;
    bit                hold_results = 1'b0;

    probe_t            probes [PROBES];
    khnd_pkg::branch_t phase_k [PHASES];

    kary_heap_node_distance_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] heap_parent(logic [63:0] u, logic [63:0] k);
        if (u <= 64'd1)
            return 64'd1;
        return (u + k - 64'd2) / k;
    endfunction

    function automatic int heap_depth(logic [63:0] u, logic [63:0] k);
        int d;
        d = 0;
        while (u > 64'd1)
        begin
            u = heap_parent(u, k);
            d++;
        end
        return d;
    endfunction

    function automatic khnd_pkg::node_t heap_distance(khnd_pkg::node_t na,
                                                      khnd_pkg::node_t nb,
                                                      khnd_pkg::branch_t k);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] kk;
        logic [63:0] steps;
        int          da;
        int          db;
        a     = (na == '0) ? 64'd1 : 64'(na);
        b     = (nb == '0) ? 64'd1 : 64'(nb);
        kk    = 64'(k);
        steps = '0;
        if (kk <= 64'd1)
            steps = (a >= b) ? a - b : b - a;
        else
        begin
            da = heap_depth(a, kk);
            db = heap_depth(b, kk);
            while (da > db)
            begin
                a = heap_parent(a, kk);
                da--;
                steps++;
            end
            while (db > da)
            begin
                b = heap_parent(b, kk);
                db--;
                steps++;
            end
            while (a != b)
            begin
                a     = heap_parent(a, kk);
                b     = heap_parent(b, kk);
                steps = steps + 64'd2;
            end
        end
        return khnd_pkg::node_t'(steps);
    endfunction

    function automatic khnd_pkg::node_t pick_node();
        logic [63:0] raw;
        int          w;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return NODE_MAX;
            default: ;
        endcase
        w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20)
                                       : $urandom_range(21, khnd_pkg::NODE_W);
        return khnd_pkg::node_t'(raw & ((64'd1 << w) - 64'd1));
    endfunction

    // climb up to six levels, then descend along random children; on a chain, move up to 64 nodes
    function automatic khnd_pkg::node_t pick_relative(khnd_pkg::node_t a,
                                                      khnd_pkg::branch_t k);
        logic [63:0] u;
        logic [63:0] kk;
        logic [63:0] child;
        int          up;
        int          down;
        kk = 64'(k);
        u  = (a == '0) ? 64'd1 : 64'(a);
        if (kk <= 64'd1)
        begin
            if ($urandom_range(0, 1))
                return khnd_pkg::node_t'(u + $urandom_range(0, 64));
            return (u > 64'd64) ? khnd_pkg::node_t'(u - $urandom_range(0, 64))
                                : khnd_pkg::node_t'(1);
        end
        up   = $urandom_range(0, 6);
        down = $urandom_range(0, 6);
        repeat (up)
            u = heap_parent(u, kk);
        for (int i = 0; i < down; i++)
        begin
            child = kk * (u - 64'd1) + 64'd2 + 64'($urandom_range(0, k - 1));
            if (child > 64'(NODE_MAX))
                break;
            u = child;
        end
        return khnd_pkg::node_t'(u);
    endfunction

    task automatic offer_pair(input khnd_pkg::node_t a, input khnd_pkg::node_t b,
                              input bit known, input khnd_pkg::node_t gold);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        node_a      <= a;
        node_b      <= b;
        typed_known <= known;
        typed_dist  <= gold;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (distance_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_branching(input khnd_pkg::branch_t k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (distance_q.size() == 0)
            begin
                $error("distance: expected nothing, actual %0d", distance);
                fail_count++;
            end
            else
            begin
                khnd_pkg::node_t want;
                want = distance_q.pop_front();
                if (distance !== want)
                begin
                    $error("distance: expected %0d, actual %0d", want, distance);
                    fail_count++;
                end
            end
        end
        if (cfg_valid && cfg_ready)
            branch_model = cfg_data;
        if (in_valid && in_ready)
            distance_q.push_back(typed_known ? typed_dist
                                             : heap_distance(node_a, node_b, branch_model));
    end

    initial
    begin : result_sink
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("** kary_heap_node_distance_core: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        khnd_pkg::branch_t k;
        khnd_pkg::node_t   a;
        khnd_pkg::node_t   b;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        node_a      <= '0;
        node_b      <= '0;
        typed_known <= 1'b0;
        typed_dist  <= '0;

        probes = '{
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1),
              khnd_pkg::node_t'(1),     1'b1, khnd_pkg::node_t'(0)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1),
              khnd_pkg::node_t'(2),     1'b1, khnd_pkg::node_t'(1)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(2),
              khnd_pkg::node_t'(3),     1'b1, khnd_pkg::node_t'(2)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(0),
              khnd_pkg::node_t'(0),     1'b1, khnd_pkg::node_t'(0)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(0),
              khnd_pkg::node_t'(3),     1'b1, khnd_pkg::node_t'(1)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(3),
              khnd_pkg::node_t'(0),     1'b1, khnd_pkg::node_t'(1)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1),
              NODE_MAX,                 1'b1, khnd_pkg::node_t'(49)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              NODE_MAX,                 1'b1, khnd_pkg::node_t'(0)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              NODE_MAX - 1,             1'b1, khnd_pkg::node_t'(2)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_TOP,
              NODE_MAX,                 1'b1, khnd_pkg::node_t'(98)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1000),
              khnd_pkg::node_t'(37),    1'b0, khnd_pkg::node_t'(0)},
            '{1'b1, khnd_pkg::branch_t'(3),    khnd_pkg::node_t'(12345),
              khnd_pkg::node_t'(678),   1'b0, khnd_pkg::node_t'(0)},
            '{1'b1, khnd_pkg::branch_t'(1023), khnd_pkg::node_t'(2),
              khnd_pkg::node_t'(1024),  1'b1, khnd_pkg::node_t'(2)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1),
              khnd_pkg::node_t'(2),     1'b1, khnd_pkg::node_t'(1)},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(1),
              khnd_pkg::node_t'(1025),  1'b1, khnd_pkg::node_t'(2)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              khnd_pkg::node_t'(1),     1'b0, khnd_pkg::node_t'(0)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              NODE_MAX,                 1'b1, khnd_pkg::node_t'(0)},
            '{1'b1, khnd_pkg::branch_t'(1),    khnd_pkg::node_t'(1),
              NODE_MAX,                 1'b1, NODE_MAX - 1},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              khnd_pkg::node_t'(1),     1'b1, NODE_MAX - 1},
            '{1'b0, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(0),
              khnd_pkg::node_t'(5),     1'b1, khnd_pkg::node_t'(4)},
            '{1'b1, khnd_pkg::branch_t'(0),    khnd_pkg::node_t'(5),
              khnd_pkg::node_t'(9),     1'b1, khnd_pkg::node_t'(4)},
            '{1'b0, khnd_pkg::branch_t'(0),    NODE_MAX,
              khnd_pkg::node_t'(0),     1'b1, NODE_MAX - 1}
        };
        phase_k = '{khnd_pkg::branch_t'(2), khnd_pkg::branch_t'(3),
                    khnd_pkg::branch_t'(1023), khnd_pkg::branch_t'(1),
                    khnd_pkg::branch_t'(0), khnd_pkg::branch_t'(2),
                    khnd_pkg::branch_t'(2), khnd_pkg::branch_t'(5),
                    khnd_pkg::branch_t'(512), khnd_pkg::branch_t'(2)};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].set_k)
            begin
                drain_results();
                load_branching(probes[i].k);
            end
            offer_pair(probes[i].a, probes[i].b, probes[i].known, probes[i].gold);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            k = (p == 5) ? khnd_pkg::branch_t'($urandom_range(2, 1022)) : phase_k[p];
            drain_results();
            load_branching(k);
            calm = (p == PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 0 && i == 20)
                    hold_results = 1'b1;
                if (p == 6 && i == 50)
                    drain_results();
                a = pick_node();
                b = ($urandom_range(0, 9) < 6) ? pick_relative(a, k) : pick_node();
                if ($urandom_range(0, 1))
                    offer_pair(a, b, 1'b0, '0);
                else
                    offer_pair(b, a, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** kary_heap_node_distance_core: PASSED **");
        else
            $display("** kary_heap_node_distance_core: FAILED **");
        $finish;
    end

endmodule
